// ----- design/assert_macros.svh -----
// Assertion helpers used by the port-level checker ivs_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define IVS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define IVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked during reset as well.
`define IVS_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ivs_pkg.sv -----
// ----------------------------------------------------------------------------
// ivs_pkg
// Shared types and constants of the intercept velocity solver.
// ----------------------------------------------------------------------------
package ivs_pkg;

    localparam int SQRT_BITS = 32;   // root bits, one pipeline stage each
    localparam int DIV_BITS  = 31;   // quotient bits, one pipeline stage each

    typedef enum logic [1:0] {
        ST_INTERCEPT  = 2'd0,
        ST_TRAIL      = 2'd1,
        ST_COINCIDENT = 2'd2,
        ST_UNREACH    = 2'd3
    } t_status;

    // Per-request data riding alongside the long arithmetic units.
    typedef struct packed {
        t_status            st;
        logic               coin;
        logic               trail;
        logic               neg_x;
        logic               neg_y;
        logic [30:0]        a_x;
        logic [30:0]        a_y;
        logic signed [31:0] u_x;
        logic signed [31:0] u_y;
        logic signed [31:0] v_x;
        logic signed [31:0] v_y;
        logic [61:0]        m_sq;
        logic signed [33:0] t;
    } t_side;

endpackage

// ----- design/intercept_velocity_solver_top.sv -----
// ----------------------------------------------------------------------------
// intercept_velocity_solver_top
// 2-D lead intercept shot velocity from positions, target velocity and speed.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with shooter and target positions, target
//   velocity and shot max speed (Q16.16). A request is taken on a clock edge
//   with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with shot velocity (Q16.16, saturated)
//   and a status code (intercept, trailing lead, coincident, unreachable).
//   Throughput: one request per cycle while the output is not stalled.
//   Pipeline: two 32-stage square root pipes and the 31-stage divider
//   pipe, plus 18 stages of subtract, multiply, normalize and rounding.
//   Stall: when the output holds a result and i_stall is high, the whole
//   pipeline freezes in place and o_stall goes high; nothing is dropped or
//   duplicated. Empty output register never stalls the input.
//   Reset: synchronous, active low; clears all valid bits.
//   No configuration, no state between requests.
// ----------------------------------------------------------------------------
module intercept_velocity_solver_top import ivs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_shooter_x,
    input  logic signed [31:0] i_shooter_y,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_vx,
    input  logic signed [31:0] i_target_vy,
    input  logic [30:0]        i_max_speed,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_shot_vx,
    output logic signed [31:0] o_shot_vy,
    output logic [1:0]         o_solve_status
);

    // round by 2^30 half away from zero, saturate to int32
    function automatic logic [31:0] round_sat(input logic [63:0] mag, input logic neg);
        logic [63:0] sum;
        logic [33:0] m;
        logic [31:0] res;
        sum = mag + 64'h0000_0000_2000_0000;
        m   = sum[63:30];
        if (neg) begin
            if (m > 34'h0_8000_0000) begin
                m = 34'h0_8000_0000;
            end
            res = 32'(~m[31:0] + 32'd1);
        end else begin
            if (m > 34'h0_7FFF_FFFF) begin
                m = 34'h0_7FFF_FFFF;
            end
            res = m[31:0];
        end
        return res;
    endfunction

    logic en;
    logic r_out_v;

    // global advance: freeze only when a held result is blocked
    assign en      = !(r_out_v && i_stall);
    assign o_stall = r_out_v && i_stall;

    // ---------------- stage 1: differences ----------------
    logic               r1_v;
    logic signed [32:0] r1_dx, r1_dy;
    logic signed [31:0] r1_vx, r1_vy;
    logic [30:0]        r1_ms;

    // ---------------- stage 2: abs, products ----------------
    logic               r2_v;
    logic [31:0]        r2_ax, r2_ay;
    logic               r2_negx, r2_negy, r2_coin;
    logic signed [63:0] r2_vxx, r2_vyy;
    logic signed [64:0] r2_px, r2_py;
    logic [61:0]        r2_msq;
    logic signed [31:0] r2_vx, r2_vy;
    logic signed [32:0] n2_ax, n2_ay;

    // ---------------- stage 3: trailing test, max ----------------
    logic               r3_v;
    logic [31:0]        r3_ax, r3_ay, r3_mx;
    t_side              r3_side, n3_side;
    logic [63:0]        n3_vsq;
    logic signed [65:0] n3_pp;

    // ---------------- stage 4: shift amount ----------------
    logic               r4_v;
    logic [31:0]        r4_ax, r4_ay;
    logic [4:0]         r4_sh, n4_sh;
    logic               r4_rsh;
    t_side              r4_side;

    // ---------------- stage 5: normalize ----------------
    logic               r5_v;
    t_side              r5_side, n5_side;

    // ---------------- stage 6: squares ----------------
    logic               r6_v;
    logic [61:0]        r6_sqx, r6_sqy;
    t_side              r6_side;

    // ---------------- stage 7: radicand ----------------
    logic               r7_v;
    logic [63:0]        r7_rad;
    t_side              r7_side;

    // norm square root
    logic               q1_v;
    logic [31:0]        q1_root;
    t_side              q1_side;

    // ---------------- stage 8: dividends ----------------
    logic               r8_v;
    logic [63:0]        r8_numx, r8_numy;
    logic [31:0]        r8_den;
    t_side              r8_side;

    // dividers
    logic                dv_v;
    logic [DIV_BITS-1:0] dv_qx, dv_qy;
    t_side               dv_side;

    // ---------------- stages 9..14: transverse speed ----------------
    logic               r9_v;
    t_side              r9_side, n9_side;

    logic               r10_v;
    logic signed [63:0] r10_pa, r10_pb;
    t_side              r10_side;

    logic               r11_v;
    logic signed [63:0] r11_raw;
    t_side              r11_side;

    logic               r12_v;
    logic [32:0]        r12_tm;
    logic               r12_tneg;
    t_side              r12_side;
    logic [63:0]        n12_mag;
    logic [63:0]        n12_sum;

    logic               r13_v;
    logic [63:0]        r13_tsq;
    t_side              r13_side, n13_side;

    logic               r14_v;
    logic [63:0]        r14_rad, n14_rad;
    t_side              r14_side, n14_side;
    logic               n14_unr;

    // longitudinal square root
    logic               q2_v;
    logic [31:0]        q2_root;
    t_side              q2_side;

    // ---------------- stages 15..17: recombine ----------------
    logic               r15_v;
    logic signed [65:0] r15_p1, r15_p2, r15_p3, r15_p4;
    t_side              r15_side;
    logic signed [32:0] n15_lng;

    logic               r16_v;
    logic signed [65:0] r16_sx, r16_sy;
    t_side              r16_side;

    logic               r17_v;
    logic [63:0]        r17_mx, r17_my;
    logic               r17_nx, r17_ny;
    t_side              r17_side;
    logic signed [65:0] n17_ax, n17_ay;

    // ---------------- output register ----------------
    logic signed [31:0] r_vx, r_vy;
    t_status            r_st;

    // ---------------- combinational pieces ----------------
    assign n2_ax = r1_dx[32] ? -r1_dx : r1_dx;
    assign n2_ay = r1_dy[32] ? -r1_dy : r1_dy;

    assign n3_vsq = $unsigned(r2_vxx) + $unsigned(r2_vyy);
    assign n3_pp  = $signed({r2_px[64], r2_px}) + $signed({r2_py[64], r2_py});

    always_comb begin
        n3_side       = '0;
        n3_side.coin  = r2_coin;
        n3_side.trail = !r2_coin && ({2'b00, r2_msq} <= n3_vsq) &&
                        !n3_pp[65] && (n3_pp != '0);
        n3_side.neg_x = r2_negx;
        n3_side.neg_y = r2_negy;
        n3_side.v_x   = r2_vx;
        n3_side.v_y   = r2_vy;
        n3_side.m_sq  = r2_msq;
    end

    // shift that brings the top set bit to position 30
    always_comb begin
        n4_sh = '0;
        for (int i = 0; i < 31; i++) begin
            if (r3_mx[i]) begin
                n4_sh = 5'(30 - i);
            end
        end
    end

    always_comb begin
        n5_side     = r4_side;
        n5_side.a_x = r4_rsh ? r4_ax[31:1] : 31'(r4_ax << r4_sh);
        n5_side.a_y = r4_rsh ? r4_ay[31:1] : 31'(r4_ay << r4_sh);
    end

    always_comb begin
        n9_side     = dv_side;
        n9_side.u_x = dv_side.neg_x ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
        n9_side.u_y = dv_side.neg_y ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
    end

    assign n12_mag = r11_raw[63] ? 64'(-r11_raw) : 64'(r11_raw);
    assign n12_sum = n12_mag + 64'h0000_0000_2000_0000;

    always_comb begin
        n13_side   = r12_side;
        n13_side.t = r12_tneg ? -$signed({1'b0, r12_tm}) : $signed({1'b0, r12_tm});
    end

    // trailing lead reuses the recombine path: L = sqrt(M^2) = M, t = 0
    assign n14_unr = r13_tsq > {2'b00, r13_side.m_sq};
    always_comb begin
        n14_side = r13_side;
        if (r13_side.trail) begin
            n14_rad    = {2'b00, r13_side.m_sq};
            n14_side.t = '0;
        end else if (n14_unr) begin
            n14_rad = '0;
        end else begin
            n14_rad = {2'b00, r13_side.m_sq} - r13_tsq;
        end
        if (r13_side.coin) begin
            n14_side.st = ST_COINCIDENT;
        end else if (r13_side.trail) begin
            n14_side.st = ST_TRAIL;
        end else if (n14_unr) begin
            n14_side.st = ST_UNREACH;
        end else begin
            n14_side.st = ST_INTERCEPT;
        end
    end

    assign n15_lng = $signed({1'b0, q2_root});

    assign n17_ax = r16_sx[65] ? -r16_sx : r16_sx;
    assign n17_ay = r16_sy[65] ? -r16_sy : r16_sy;

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r6_v    <= 1'b0;
            r7_v    <= 1'b0;
            r8_v    <= 1'b0;
            r9_v    <= 1'b0;
            r10_v   <= 1'b0;
            r11_v   <= 1'b0;
            r12_v   <= 1'b0;
            r13_v   <= 1'b0;
            r14_v   <= 1'b0;
            r15_v   <= 1'b0;
            r16_v   <= 1'b0;
            r17_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            r6_v    <= r5_v;
            r7_v    <= r6_v;
            r8_v    <= q1_v;
            r9_v    <= dv_v;
            r10_v   <= r9_v;
            r11_v   <= r10_v;
            r12_v   <= r11_v;
            r13_v   <= r12_v;
            r14_v   <= r13_v;
            r15_v   <= q2_v;
            r16_v   <= r15_v;
            r17_v   <= r16_v;
            r_out_v <= r17_v;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx <= $signed({i_target_x[31], i_target_x}) -
                     $signed({i_shooter_x[31], i_shooter_x});
            r1_dy <= $signed({i_target_y[31], i_target_y}) -
                     $signed({i_shooter_y[31], i_shooter_y});
            r1_vx <= i_target_vx;
            r1_vy <= i_target_vy;
            r1_ms <= i_max_speed;

            r2_ax   <= n2_ax[31:0];
            r2_ay   <= n2_ay[31:0];
            r2_negx <= r1_dx[32];
            r2_negy <= r1_dy[32];
            r2_coin <= (r1_dx == '0) && (r1_dy == '0);
            r2_vxx  <= r1_vx * r1_vx;
            r2_vyy  <= r1_vy * r1_vy;
            r2_px   <= r1_dx * r1_vx;
            r2_py   <= r1_dy * r1_vy;
            r2_msq  <= r1_ms * r1_ms;
            r2_vx   <= r1_vx;
            r2_vy   <= r1_vy;

            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
            r3_mx   <= (r2_ax > r2_ay) ? r2_ax : r2_ay;
            r3_side <= n3_side;

            r4_ax   <= r3_ax;
            r4_ay   <= r3_ay;
            r4_sh   <= n4_sh;
            r4_rsh  <= r3_mx[31];
            r4_side <= r3_side;

            r5_side <= n5_side;

            r6_sqx  <= r5_side.a_x * r5_side.a_x;
            r6_sqy  <= r5_side.a_y * r5_side.a_y;
            r6_side <= r5_side;

            r7_rad  <= {2'b00, r6_sqx} + {2'b00, r6_sqy};
            r7_side <= r6_side;

            r8_numx <= {3'b000, q1_side.a_x, 30'd0} + {33'd0, q1_root[31:1]};
            r8_numy <= {3'b000, q1_side.a_y, 30'd0} + {33'd0, q1_root[31:1]};
            r8_den  <= q1_root;
            r8_side <= q1_side;

            r9_side <= n9_side;

            r10_pa   <= r9_side.u_y * r9_side.v_x;
            r10_pb   <= r9_side.u_x * r9_side.v_y;
            r10_side <= r9_side;

            r11_raw  <= r10_pa - r10_pb;
            r11_side <= r10_side;

            r12_tm   <= n12_sum[62:30];
            r12_tneg <= r11_raw[63];
            r12_side <= r11_side;

            r13_tsq  <= {31'd0, r12_tm} * {31'd0, r12_tm};
            r13_side <= n13_side;

            r14_rad  <= n14_rad;
            r14_side <= n14_side;

            r15_p1   <= q2_side.u_x * n15_lng;
            r15_p2   <= q2_side.u_y * q2_side.t;
            r15_p3   <= q2_side.u_y * n15_lng;
            r15_p4   <= q2_side.u_x * q2_side.t;
            r15_side <= q2_side;

            r16_sx   <= r15_p1 + r15_p2;
            r16_sy   <= r15_p3 - r15_p4;
            r16_side <= r15_side;

            r17_mx   <= n17_ax[63:0];
            r17_my   <= n17_ay[63:0];
            r17_nx   <= r16_sx[65];
            r17_ny   <= r16_sy[65];
            r17_side <= r16_side;

            r_vx <= r17_side.coin ? '0 : $signed(round_sat(r17_mx, r17_nx));
            r_vy <= r17_side.coin ? '0 : $signed(round_sat(r17_my, r17_ny));
            r_st <= r17_side.st;
        end
    end

    // ---------------- long units ----------------
    ivs_sqrt u_norm_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_v),
        .i_rad   (r7_rad),
        .i_side  (r7_side),
        .o_valid (q1_v),
        .o_root  (q1_root),
        .o_side  (q1_side)
    );

    ivs_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_v),
        .i_num   (r8_numx),
        .i_den   (r8_den),
        .i_side  (r8_side),
        .o_valid (dv_v),
        .o_quo   (dv_qx),
        .o_side  (dv_side)
    );

    ivs_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_v),
        .i_num   (r8_numy),
        .i_den   (r8_den),
        .i_side  (r8_side),
        .o_valid (),
        .o_quo   (dv_qy),
        .o_side  ()
    );

    ivs_sqrt u_long_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r14_v),
        .i_rad   (r14_rad),
        .i_side  (r14_side),
        .o_valid (q2_v),
        .o_root  (q2_root),
        .o_side  (q2_side)
    );

    assign o_valid        = r_out_v;
    assign o_shot_vx      = r_vx;
    assign o_shot_vy      = r_vy;
    assign o_solve_status = r_st;

endmodule

// ----- design/ivs_sqrt.sv -----
// ----------------------------------------------------------------------------
// ivs_sqrt
// Pipelined integer square root, floor(sqrt(rad)), one root bit per stage.
// ----------------------------------------------------------------------------
module ivs_sqrt import ivs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_rad,
    input  t_side       i_side,
    output logic        o_valid,
    output logic [31:0] o_root,
    output t_side       o_side
);

    logic        r_v    [SQRT_BITS];
    logic [63:0] r_rem  [SQRT_BITS];
    logic [63:0] r_root [SQRT_BITS];
    t_side       r_side [SQRT_BITS];

    for (genvar s = 0; s < SQRT_BITS; s++) begin : g_stage
        logic        v_in;
        logic [63:0] rem_in;
        logic [63:0] root_in;
        t_side       side_in;
        logic [63:0] bit_w;
        logic [64:0] trial;
        logic [63:0] n_rem;
        logic [63:0] n_root;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_rad;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[s-1];
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign side_in = r_side[s-1];
        end

        assign bit_w = 64'd1 << (2 * (SQRT_BITS - 1 - s));
        assign trial = {1'b0, root_in} + {1'b0, bit_w};

        always_comb begin
            if ({1'b0, rem_in} >= trial) begin
                n_rem  = rem_in - trial[63:0];
                n_root = (root_in >> 1) + bit_w;
            end else begin
                n_rem  = rem_in;
                n_root = root_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid = r_v[SQRT_BITS-1];
    assign o_root  = r_root[SQRT_BITS-1][31:0];
    assign o_side  = r_side[SQRT_BITS-1];

endmodule

// ----- design/ivs_div.sv -----
// ----------------------------------------------------------------------------
// ivs_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ivs_div import ivs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [63:0]         i_num,
    input  logic [31:0]         i_den,
    input  t_side               i_side,
    output logic                o_valid,
    output logic [DIV_BITS-1:0] o_quo,
    output t_side               o_side
);

    logic                r_v   [DIV_BITS];
    logic [63:0]         r_rem [DIV_BITS];
    logic [31:0]         r_den [DIV_BITS];
    logic [DIV_BITS-1:0] r_q   [DIV_BITS];
    t_side               r_side[DIV_BITS];

    for (genvar s = 0; s < DIV_BITS; s++) begin : g_stage
        logic                v_in;
        logic [63:0]         rem_in;
        logic [31:0]         den_in;
        logic [DIV_BITS-1:0] q_in;
        t_side               side_in;
        logic [63:0]         trial;
        logic [63:0]         n_rem;
        logic [DIV_BITS-1:0] n_q;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_num;
            assign den_in  = i_den;
            assign q_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[s-1];
            assign rem_in  = r_rem[s-1];
            assign den_in  = r_den[s-1];
            assign q_in    = r_q[s-1];
            assign side_in = r_side[s-1];
        end

        assign trial = {32'd0, den_in} << (DIV_BITS - 1 - s);

        always_comb begin
            n_q = q_in;
            if (rem_in >= trial) begin
                n_rem                  = rem_in - trial;
                n_q[DIV_BITS - 1 - s]  = 1'b1;
            end else begin
                n_rem = rem_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_den[s]  <= den_in;
                r_q[s]    <= n_q;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid = r_v[DIV_BITS-1];
    assign o_quo   = r_q[DIV_BITS-1];
    assign o_side  = r_side[DIV_BITS-1];

endmodule

// ----- design/ivs_chk.sv -----
// ----------------------------------------------------------------------------
// ivs_chk
// Port-level checks on the solver, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ivs_chk import ivs_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_shot_vx,
    input logic signed [31:0] o_shot_vy,
    input logic [1:0]         o_solve_status
);

    `IVS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_shot_vx) && $stable(o_shot_vy) && $stable(o_solve_status), "stalled result changed")
    `IVS_ASSERT_NOW(a_coin_zero, o_valid && (o_solve_status == ST_COINCIDENT), (o_shot_vx == '0) && (o_shot_vy == '0), "coincident result not zero")
    `IVS_ASSERT_NOW(a_stall_src, o_stall, o_valid && i_stall, "input stalled without blocked output")
    `IVS_ASSERT_RST(a_rst_empty, !i_rst_n, !o_valid && !o_stall, "output busy after reset")

endmodule

bind intercept_velocity_solver_top ivs_chk u_ivs_chk (.*);

// ----- dv/intercept_velocity_solver_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intercept_velocity_solver_checker
// Watches both channels, computes the expected shot velocity of every accepted
// request and compares each accepted result against the oldest expectation.
// ----------------------------------------------------------------------------
module intercept_velocity_solver_checker import ivs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic signed [31:0] i_shooter_x,
    input  logic signed [31:0] i_shooter_y,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_vx,
    input  logic signed [31:0] i_target_vy,
    input  logic [30:0]        i_max_speed,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [31:0] o_shot_vx,
    input  logic signed [31:0] o_shot_vy,
    input  logic [1:0]         o_solve_status,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        t_status            st;
    } t_shot;

    t_shot shot_q[$];

    assign o_pending = shot_q.size();

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r = 0;
        rem = n;
        b = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // divide by 2^30, half away from zero, clamp to int32
    function automatic logic signed [31:0] q30_to_sat(input logic signed [127:0] v);
        logic               neg;
        logic [127:0]       m;
        neg = v < 0;
        m = neg ? -v : v;
        m = (m + (128'd1 << 29)) >> 30;
        if (neg) begin
            if (m > 128'h80000000) m = 128'h80000000;
            return -$signed(m[32:0]);
        end
        if (m > 128'h7FFFFFFF) m = 128'h7FFFFFFF;
        return m[31:0];
    endfunction

    function automatic t_shot solve_shot(
        input logic signed [31:0] sx, sy, tx, ty, vx, vy,
        input logic [30:0] ms);
        t_shot               r;
        logic signed [127:0] dx, dy, ux, uy, t, lng, raw, px, py;
        logic [127:0]        ax, ay, mx, nrm, uxm, uym, msq, vsq, tm, tsq;
        dx = $signed(tx) - $signed(sx);
        dy = $signed(ty) - $signed(sy);
        if (dx == 0 && dy == 0) begin
            r.vx = 0; r.vy = 0; r.st = ST_COINCIDENT;
            return r;
        end
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        mx = ax > ay ? ax : ay;
        if (mx >= 128'h80000000) begin
            ax = ax >> 1; ay = ay >> 1;
        end else begin
            while (mx < 128'h40000000) begin
                ax = ax << 1; ay = ay << 1; mx = mx << 1;
            end
        end
        nrm = int_sqrt(64'(ax * ax + ay * ay));
        uxm = ((ax << 30) + nrm / 2) / nrm;
        uym = ((ay << 30) + nrm / 2) / nrm;
        ux = dx < 0 ? -$signed(uxm) : $signed(uxm);
        uy = dy < 0 ? -$signed(uym) : $signed(uym);
        msq = 128'(ms) * 128'(ms);
        vsq = $signed(vx) * $signed(vx) + $signed(vy) * $signed(vy);
        px = dx * $signed(vx);
        py = dy * $signed(vy);
        if (msq <= vsq && px > -py) begin
            r.vx = q30_to_sat(ux * $signed({1'b0, ms}));
            r.vy = q30_to_sat(uy * $signed({1'b0, ms}));
            r.st = ST_TRAIL;
            return r;
        end
        raw = uy * $signed(vx) - ux * $signed(vy);
        tm = raw < 0 ? -raw : raw;
        tm = (tm + (128'd1 << 29)) >> 30;
        t = raw < 0 ? -$signed(tm) : $signed(tm);
        tsq = tm * tm;
        if (tsq > msq) begin
            lng = 0;
            r.st = ST_UNREACH;
        end else begin
            lng = $signed(128'(int_sqrt(64'(msq - tsq))));
            r.st = ST_INTERCEPT;
        end
        r.vx = q30_to_sat(ux * lng + uy * t);
        r.vy = q30_to_sat(uy * lng - ux * t);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_shot exp_s;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_valid && !o_stall)
                shot_q.push_back(solve_shot(i_shooter_x, i_shooter_y, i_target_x,
                    i_target_y, i_target_vx, i_target_vy, i_max_speed));
            if (o_valid && !i_stall) begin
                if (shot_q.size() == 0) begin
                    $error("result with no request pending");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_s = shot_q.pop_front();
                    if (o_shot_vx !== exp_s.vx || o_shot_vy !== exp_s.vy ||
                        o_solve_status !== exp_s.st) begin
                        if (o_shot_vx !== exp_s.vx)
                            $error("shot_vx expected %0d actual %0d", exp_s.vx, o_shot_vx);
                        if (o_shot_vy !== exp_s.vy)
                            $error("shot_vy expected %0d actual %0d", exp_s.vy, o_shot_vy);
                        if (o_solve_status !== exp_s.st)
                            $error("solve_status expected %0d actual %0d",
                                exp_s.st, o_solve_status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- dv/tb_intercept_velocity_solver_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_intercept_velocity_solver_top
// Drives directed and random solve requests into the solver with random idle
// and stall on both channels, plus one long output hold-off; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_intercept_velocity_solver_top;
    import ivs_pkg::*;

    localparam int LATENCY   = 113;
    localparam int N_RANDOM  = 1900;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_shooter_x, i_shooter_y, i_target_x, i_target_y;
    logic signed [31:0] i_target_vx, i_target_vy;
    logic [30:0]        i_max_speed;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_shot_vx, o_shot_vy;
    logic [1:0]         o_solve_status;
    int                 fail_count;
    int                 pending;
    logic               sending_done;
    bit                 quiet_phase;   // no idling from either side

    intercept_velocity_solver_top dut (.*);

    intercept_velocity_solver_checker checker_i (
        .*, .o_fail_count(fail_count), .o_pending(pending));

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Random Q16.16 coordinate: mostly modest, sometimes full-range or extreme.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            2: return $signed($urandom_range(0, 64)) - 32;      // tiny offsets
            default: return $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF;
        endcase
    endfunction

    function automatic logic [30:0] rand_speed();
        case ($urandom_range(0, 7))
            0: return 31'($urandom());
            1: return $urandom_range(0, 1) ? 31'h7FFFFFFF : 31'd0;
            default: return 31'($urandom_range(0, 32'h00FFFFFF));
        endcase
    endfunction

    // Offer one request; hold it steady until accepted.
    task automatic send_request(input logic [31:0] sx, sy, tx, ty, vx, vy,
                                input logic [30:0] ms);
        while (!quiet_phase && $urandom_range(0, 99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_shooter_x <= sx;
        i_shooter_y <= sy;
        i_target_x  <= tx;
        i_target_y  <= ty;
        i_target_vx <= vx;
        i_target_vy <= vy;
        i_max_speed <= ms;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Receiver: random stall, plus one long hold-off while requests keep coming.
    initial begin
        int hold;
        i_stall = 1'b1;
        @(posedge i_clk iff i_rst_n);
        repeat (300) @(posedge i_clk) i_stall <= ($urandom_range(0, 99) < 21);
        @(posedge i_clk) i_stall <= 1'b1;
        for (hold = 0; hold < 400; hold++) @(posedge i_clk);
        forever @(posedge i_clk)
            i_stall <= quiet_phase ? 1'b0 : ($urandom_range(0, 99) < 21);
    end

    initial begin
        int      n;
        logic [31:0] sx, sy, tx, ty;
        i_valid = 0; i_shooter_x = 0; i_shooter_y = 0; i_target_x = 0;
        i_target_y = 0; i_target_vx = 0; i_target_vy = 0; i_max_speed = 0;
        i_rst_n = 0; sending_done = 0; quiet_phase = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: coincident, axes, trailing lead, unreachable, extremes
        send_request(0, 0, 0, 0, 32'h10000, 0, 31'h20000);
        send_request(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 31'd0);
        send_request(0, 0, 32'h100000, 0, 0, 32'h10000, 31'h20000);
        send_request(0, 0, 0, 32'h100000, 32'h10000, 0, 31'h20000);
        send_request(0, 0, 32'h100000, 0, 32'h30000, 0, 31'h20000);   // trailing
        send_request(0, 0, 32'h100000, 0, 32'h20000, 0, 31'h20000);   // equal speed away
        send_request(0, 0, 32'h100000, 0, -32'sh30000, 0, 31'h20000); // faster, closing
        send_request(0, 0, 32'h100000, 0, 0, 32'h50000, 31'h20000);   // unreachable
        send_request(0, 0, 32'h100000, 0, 0, 32'h50000, 31'd0);
        send_request(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                     32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF);
        send_request(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                     32'h80000000, 32'h80000000, 31'h7FFFFFFF);
        send_request(32'h7FFFFFFF, 0, 32'h80000000, 0, 32'h80000000, 0, 31'h7FFFFFFF);
        send_request(0, 0, 1, 0, 0, 32'hFFFFFFFF, 31'h1);
        send_request(0, 0, 1, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF);
        send_request(32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 32'hFFFFFFFF, 1, 31'h55555555);
        send_request(32'h12345, 32'h6789A, 32'h12345, 32'h6789B, 32'h80000000,
                     32'h7FFFFFFF, 31'h2AAAAAAA);

        for (n = 0; n < N_RANDOM; n++) begin
            quiet_phase = (n >= 900 && n < 1200);
            sx = rand_coord(); sy = rand_coord();
            if ($urandom_range(0, 29) == 0) begin
                tx = sx; ty = sy;
            end else begin
                tx = rand_coord(); ty = rand_coord();
            end
            send_request(sx, sy, tx, ty, rand_coord(), rand_coord(), rand_speed());
        end
        i_valid <= 1'b0;
        quiet_phase = 0;
        sending_done = 1;
    end

    initial begin
        int drain;
        wait (sending_done);
        while (pending != 0) @(posedge i_clk);
        for (drain = 0; drain < 2 * LATENCY; drain++) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #4ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/ivs_pkg.sv
design/ivs_sqrt.sv
design/ivs_div.sv
design/intercept_velocity_solver_top.sv
design/ivs_chk.sv
dv/intercept_velocity_solver_checker.sv
dv/tb_intercept_velocity_solver_top.sv
